>>> src/mlpid_pkg.sv
// shared types, constants and register map of the multi-law pid controller
`timescale 1ns / 1ps
`default_nettype none

package mlpid_pkg;

  localparam int SIGNAL_WIDTH_DEF   = 32;
  localparam int GAIN_FRAC_BITS_DEF = 20;

  localparam int GAIN_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int ES_W    = LIMIT_W + 1;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int IDX_W   = 3;

  // register indexes, byte address is 4 * index
  localparam logic [IDX_W-1:0] REG_LAW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAINP = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAINI = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIND = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    LAW_PID     = 2'd0,
    LAW_PI_ERR  = 2'd1,
    LAW_IP_MEAS = 2'd2,
    LAW_PD      = 2'd3
  } law_e;

  typedef struct packed {
    law_e               law;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  // per-stage control that travels with an item
  typedef struct packed {
    logic vld;
    logic clr;
    logic accum;
  } ctrl_t;

endpackage

`default_nettype wire

>>> src/multi_law_pid_controller.sv
// an accepted item moves through the operand, product and result registers to the output
// one item per cycle unless stalled; operand, product and result stages advance together
// a stalled output holds the whole pipeline, s_tready follows the output slot
// the accumulator loop closes within the result stage, the others within the input stage
// reset (rst_ni low, asynchronous) clears config, stored state and pipeline valids
`timescale 1ns / 1ps
`default_nettype none

module multi_law_pid_controller #(
  parameter int SIGNAL_WIDTH   = mlpid_pkg::SIGNAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = mlpid_pkg::GAIN_FRAC_BITS_DEF,
  parameter int IN_W           = ((2 * SIGNAL_WIDTH + 7) / 8) * 8,
  parameter int OUT_W          = ((SIGNAL_WIDTH + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlpid_pkg::APB_AW-1:0] paddr,
  input  wire logic [mlpid_pkg::APB_DW-1:0] pwdata,
  output logic      [mlpid_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  // sample stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [IN_W-1:0]              s_tdata,  // measurement, setpoint, zero pad
  input  wire logic [0:0]                   s_tuser,  // clear
  // drive stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [OUT_W-1:0]             m_tdata,  // drive, zero pad
  output logic      [0:0]                   m_tuser   // saturated
);

  localparam int OP_W   = (SIGNAL_WIDTH + 2 > mlpid_pkg::ES_W) ?
                          SIGNAL_WIDTH + 2 : mlpid_pkg::ES_W;
  localparam int PROD_W = OP_W + mlpid_pkg::GAIN_W + 1;

  mlpid_pkg::cfg_t                cfg;
  mlpid_pkg::ctrl_t               ctrl_a, ctrl_b;
  logic                           en, take, out_vld, out_sat;
  logic signed [SIGNAL_WIDTH-1:0] meas, setp, drive;
  logic signed [OP_W-1:0]         op_p, op_i, op_d;
  logic signed [PROD_W-1:0]       prod_p, prod_i, prod_d;

  assign en       = !out_vld || m_tready;
  assign take     = s_tvalid && en;
  assign s_tready = en;
  assign meas     = $signed(s_tdata[SIGNAL_WIDTH-1:0]);
  assign setp     = $signed(s_tdata[2*SIGNAL_WIDTH-1:SIGNAL_WIDTH]);

  mlpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlpid_front #(
    .SIGNAL_WIDTH (SIGNAL_WIDTH),
    .OP_W         (OP_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .take_i  (take),
    .meas_i  (meas),
    .setp_i  (setp),
    .clear_i (s_tuser[0]),
    .law_i   (cfg.law),
    .limit_i (cfg.limit),
    .op_p_o  (op_p),
    .op_i_o  (op_i),
    .op_d_o  (op_d),
    .ctrl_o  (ctrl_a)
  );

  mlpid_mult #(
    .OP_W   (OP_W),
    .PROD_W (PROD_W)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .op_p_i   (op_p),
    .op_i_i   (op_i),
    .op_d_i   (op_d),
    .cfg_i    (cfg),
    .ctrl_i   (ctrl_a),
    .prod_p_o (prod_p),
    .prod_i_o (prod_i),
    .prod_d_o (prod_d),
    .ctrl_o   (ctrl_b)
  );

  mlpid_back #(
    .SIGNAL_WIDTH   (SIGNAL_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .PROD_W         (PROD_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .prod_p_i (prod_p),
    .prod_i_i (prod_i),
    .prod_d_i (prod_d),
    .ctrl_i   (ctrl_b),
    .drive_o  (drive),
    .sat_o    (out_sat),
    .vld_o    (out_vld)
  );

  assign m_tvalid   = out_vld;
  assign m_tdata    = OUT_W'($unsigned(drive));
  assign m_tuser[0] = out_sat;

endmodule

`default_nettype wire

>>> src/mlpid_regs.sv
// apb configuration registers of the pid controller
`timescale 1ns / 1ps
`default_nettype none

module mlpid_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlpid_pkg::APB_AW-1:0] paddr,
  input  wire logic [mlpid_pkg::APB_DW-1:0] pwdata,
  output logic      [mlpid_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  output mlpid_pkg::cfg_t                   cfg_o
);

  mlpid_pkg::cfg_t             cfg_q;
  logic [mlpid_pkg::IDX_W-1:0] idx;
  logic                        wr;

  assign idx    = paddr[mlpid_pkg::APB_AW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.law    <= mlpid_pkg::LAW_PID;
      cfg_q.gain_p <= '0;
      cfg_q.gain_i <= '0;
      cfg_q.gain_d <= '0;
      cfg_q.limit  <= '0;
    end else if (wr) begin
      unique case (idx)
        mlpid_pkg::REG_LAW:   cfg_q.law    <= mlpid_pkg::law_e'(pwdata[1:0]);
        mlpid_pkg::REG_GAINP: cfg_q.gain_p <= pwdata;
        mlpid_pkg::REG_GAINI: cfg_q.gain_i <= pwdata;
        mlpid_pkg::REG_GAIND: cfg_q.gain_d <= pwdata;
        mlpid_pkg::REG_LIMIT: cfg_q.limit  <= pwdata[mlpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mlpid_pkg::REG_LAW:   prdata = mlpid_pkg::APB_DW'(cfg_q.law);
      mlpid_pkg::REG_GAINP: prdata = cfg_q.gain_p;
      mlpid_pkg::REG_GAINI: prdata = cfg_q.gain_i;
      mlpid_pkg::REG_GAIND: prdata = cfg_q.gain_d;
      mlpid_pkg::REG_LIMIT: prdata = mlpid_pkg::APB_DW'(cfg_q.limit);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mlpid_front.sv
// input stage: error, integral clamp, stored previous term and multiplier operands
`timescale 1ns / 1ps
`default_nettype none

module mlpid_front #(
  parameter int SIGNAL_WIDTH = mlpid_pkg::SIGNAL_WIDTH_DEF,
  parameter int OP_W         = SIGNAL_WIDTH + 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                take_i,
  input  wire logic signed [SIGNAL_WIDTH-1:0]      meas_i,
  input  wire logic signed [SIGNAL_WIDTH-1:0]      setp_i,
  input  wire logic                                clear_i,
  input  wire mlpid_pkg::law_e                     law_i,
  input  wire logic        [mlpid_pkg::LIMIT_W-1:0] limit_i,
  output logic signed      [OP_W-1:0]              op_p_o,
  output logic signed      [OP_W-1:0]              op_i_o,
  output logic signed      [OP_W-1:0]              op_d_o,
  output mlpid_pkg::ctrl_t                         ctrl_o
);

  localparam int E_W   = SIGNAL_WIDTH + 1;
  localparam int D_W   = SIGNAL_WIDTH + 2;
  localparam int ESS_W = ((E_W > mlpid_pkg::ES_W) ? E_W : mlpid_pkg::ES_W) + 1;

  logic signed [E_W-1:0]            prev_q, prev_d;
  logic signed [mlpid_pkg::ES_W-1:0] es_q, es_d;
  logic signed [E_W-1:0]            err;
  logic signed [D_W-1:0]            diff_e, neg_diff_m;
  logic signed [ESS_W-1:0]          es_sum, lim_pos, lim_neg, es_clamp;
  logic signed [OP_W-1:0]           op_p_d, op_i_d, op_d_d;
  logic signed [OP_W-1:0]           op_p_q, op_i_q, op_d_q;
  mlpid_pkg::ctrl_t                 ctrl_q;

  always_comb begin
    err        = E_W'(setp_i) - E_W'(meas_i);
    diff_e     = D_W'(err) - D_W'(prev_q);
    neg_diff_m = D_W'(prev_q) - D_W'(meas_i);

    // running error sum, clamped symmetrically
    es_sum  = ESS_W'(es_q) + ESS_W'(err);
    lim_pos = $signed(ESS_W'(limit_i));
    lim_neg = -lim_pos;
    if (es_sum > lim_pos) begin
      es_clamp = lim_pos;
    end else if (es_sum < lim_neg) begin
      es_clamp = lim_neg;
    end else begin
      es_clamp = es_sum;
    end

    es_d   = es_q;
    prev_d = err;
    op_p_d = OP_W'(err);
    op_i_d = '0;
    op_d_d = '0;
    unique case (law_i)
      mlpid_pkg::LAW_PID: begin
        es_d   = mlpid_pkg::ES_W'(es_clamp);
        op_i_d = OP_W'(es_d);
        op_d_d = OP_W'(diff_e);
      end
      mlpid_pkg::LAW_PI_ERR: begin
        op_p_d = OP_W'(diff_e);
        op_i_d = OP_W'(err);
      end
      mlpid_pkg::LAW_IP_MEAS: begin
        // proportional on measurement, sign folded into the operand
        op_p_d = OP_W'(neg_diff_m);
        op_i_d = OP_W'(err);
        prev_d = E_W'(meas_i);
      end
      mlpid_pkg::LAW_PD: begin
        op_d_d = OP_W'(diff_e);
      end
    endcase

    if (clear_i) begin
      es_d   = '0;
      prev_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      es_q   <= '0;
      ctrl_q <= '0;
    end else begin
      if (take_i) begin
        prev_q <= prev_d;
        es_q   <= es_d;
      end
      if (en_i) begin
        ctrl_q.vld   <= take_i;
        ctrl_q.clr   <= clear_i;
        ctrl_q.accum <= (law_i == mlpid_pkg::LAW_PI_ERR) ||
                        (law_i == mlpid_pkg::LAW_IP_MEAS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_p_q <= op_p_d;
      op_i_q <= op_i_d;
      op_d_q <= op_d_d;
    end
  end

  assign op_p_o = op_p_q;
  assign op_i_o = op_i_q;
  assign op_d_o = op_d_q;
  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

>>> src/mlpid_mult.sv
// product stage: the three gain multipliers, registered
`timescale 1ns / 1ps
`default_nettype none

module mlpid_mult #(
  parameter int OP_W   = 34,
  parameter int PROD_W = OP_W + mlpid_pkg::GAIN_W + 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic signed [OP_W-1:0]          op_p_i,
  input  wire logic signed [OP_W-1:0]          op_i_i,
  input  wire logic signed [OP_W-1:0]          op_d_i,
  input  wire mlpid_pkg::cfg_t                 cfg_i,
  input  wire mlpid_pkg::ctrl_t                ctrl_i,
  output logic signed      [PROD_W-1:0]        prod_p_o,
  output logic signed      [PROD_W-1:0]        prod_i_o,
  output logic signed      [PROD_W-1:0]        prod_d_o,
  output mlpid_pkg::ctrl_t                     ctrl_o
);

  logic signed [mlpid_pkg::GAIN_W:0] gp, gi, gd;
  logic signed [PROD_W-1:0]          prod_p_q, prod_i_q, prod_d_q;
  mlpid_pkg::ctrl_t                  ctrl_q;

  // gains are unsigned, widened by a zero sign bit
  assign gp = $signed({1'b0, cfg_i.gain_p});
  assign gi = $signed({1'b0, cfg_i.gain_i});
  assign gd = $signed({1'b0, cfg_i.gain_d});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_p_q <= PROD_W'(op_p_i) * PROD_W'(gp);
      prod_i_q <= PROD_W'(op_i_i) * PROD_W'(gi);
      prod_d_q <= PROD_W'(op_d_i) * PROD_W'(gd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  assign prod_p_o = prod_p_q;
  assign prod_i_o = prod_i_q;
  assign prod_d_o = prod_d_q;
  assign ctrl_o   = ctrl_q;

endmodule

`default_nettype wire

>>> src/mlpid_back.sv
// result stage: term sum, scaling, accumulator, saturation and output register
`timescale 1ns / 1ps
`default_nettype none

module mlpid_back #(
  parameter int SIGNAL_WIDTH   = mlpid_pkg::SIGNAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = mlpid_pkg::GAIN_FRAC_BITS_DEF,
  parameter int PROD_W         = 67
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic signed [PROD_W-1:0]       prod_p_i,
  input  wire logic signed [PROD_W-1:0]       prod_i_i,
  input  wire logic signed [PROD_W-1:0]       prod_d_i,
  input  wire mlpid_pkg::ctrl_t               ctrl_i,
  output logic signed      [SIGNAL_WIDTH-1:0] drive_o,
  output logic                                sat_o,
  output logic                                vld_o
);

  localparam int SUM_W = PROD_W + 2;
  localparam int T_W   = SUM_W + 1;
  localparam int HI_W  = T_W - SIGNAL_WIDTH + 1;
  localparam logic signed [SIGNAL_WIDTH-1:0] MAX_V = {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
  localparam logic signed [SIGNAL_WIDTH-1:0] MIN_V = {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0]        sum, scaled;
  logic signed [T_W-1:0]          total;
  logic        [HI_W-1:0]         hi;
  logic signed [SIGNAL_WIDTH-1:0] oacc_q, oacc_d;
  logic signed [SIGNAL_WIDTH-1:0] drive_d, drive_q;
  logic                           sat_d, sat_q, vld_q;

  always_comb begin
    sum    = SUM_W'(prod_p_i) + SUM_W'(prod_i_i) + SUM_W'(prod_d_i);
    // floor scaling back to the signal format
    scaled = sum >>> GAIN_FRAC_BITS;
    total  = ctrl_i.accum ? (T_W'(scaled) + T_W'(oacc_q)) : T_W'(scaled);
    hi     = total[T_W-1:SIGNAL_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      drive_d = total[SIGNAL_WIDTH-1:0];
      sat_d   = 1'b0;
    end else begin
      drive_d = total[T_W-1] ? MIN_V : MAX_V;
      sat_d   = 1'b1;
    end
    oacc_d = ctrl_i.accum ? drive_d : oacc_q;
    if (ctrl_i.clr) begin
      drive_d = '0;
      sat_d   = 1'b0;
      oacc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oacc_q <= '0;
      vld_q  <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctrl_i.vld;
      if (ctrl_i.vld) begin
        oacc_q <= oacc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign drive_o = drive_q;
  assign sat_o   = sat_q;
  assign vld_o   = vld_q;

endmodule

`default_nettype wire

>>> src/mlpid_checker.sv
// port-level checks of the pid controller and their binding
`timescale 1ns / 1ps
`default_nettype none

module mlpid_checker #(
  parameter int SIGNAL_WIDTH = mlpid_pkg::SIGNAL_WIDTH_DEF,
  parameter int OUT_W        = ((SIGNAL_WIDTH + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic [0:0]       m_tuser
);

  localparam logic [SIGNAL_WIDTH-1:0] MAX_V = {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
  localparam logic [SIGNAL_WIDTH-1:0] MIN_V = {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input side is ready exactly when the output slot is free or being freed
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow the output slot");

  // a clipped drive sits on a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |->
      (m_tdata[SIGNAL_WIDTH-1:0] == MAX_V) || (m_tdata[SIGNAL_WIDTH-1:0] == MIN_V))
    else $error("saturated drive not at a limit");

endmodule

bind multi_law_pid_controller mlpid_checker #(
  .SIGNAL_WIDTH (SIGNAL_WIDTH),
  .OUT_W        (OUT_W)
) u_mlpid_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> verif/multi_law_pid_controller_tb.sv
// self-checking testbench for the multi-law pid controller with its own drive predictor
`timescale 1ns / 1ps

module multi_law_pid_controller_tb;
  import mlpid_pkg::*;

  localparam int SIG_W          = SIGNAL_WIDTH_DEF;
  localparam int FRAC_BITS      = GAIN_FRAC_BITS_DEF;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 24;
  localparam int QUIET_PHASE    = 5;
  localparam int PRESSURE_PHASE = 12;

  // expected drive values of a multi-law pid loop, with a mirror of its registers and state
  class drive_scoreboard;
    typedef struct {
      logic [SIG_W-1:0] drive;
      logic             sat;
    } drive_t;

    law_e                law;
    logic [GAIN_W-1:0]   kp, ki, kd;
    logic [LIMIT_W-1:0]  limit;
    logic signed [127:0] prev_term, err_sum, out_acc;
    drive_t              expected_q[$];
    int                  mismatches;

    function new();
      law        = LAW_PID;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      limit      = '0;
      prev_term  = '0;
      err_sum    = '0;
      out_acc    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_LAW:   law   = law_e'(value[1:0]);
        REG_GAINP: kp    = value;
        REG_GAINI: ki    = value;
        REG_GAIND: kd    = value;
        REG_LIMIT: limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] scale(logic signed [127:0] a, logic [GAIN_W-1:0] g);
      return a * $signed({96'd0, g});
    endfunction

    function void clip(logic signed [127:0] v, output drive_t r);
      logic signed [127:0] maxv, minv;
      maxv = (128'sd1 <<< (SIG_W - 1)) - 128'sd1;
      minv = -maxv - 128'sd1;
      r.sat = 1'b1;
      if (v > maxv) r.drive = maxv[SIG_W-1:0];
      else if (v < minv) r.drive = minv[SIG_W-1:0];
      else begin
        r.drive = v[SIG_W-1:0];
        r.sat   = 1'b0;
      end
    endfunction

    function void note_sample(logic [SIG_W-1:0] meas, logic [SIG_W-1:0] sp, logic clr);
      logic signed [127:0] m, e, lim, acc;
      drive_t              r;
      m   = $signed(meas);
      e   = $signed(sp) - $signed(meas);
      lim = $signed({97'd0, limit});
      if (clr) begin
        prev_term = '0;
        err_sum   = '0;
        out_acc   = '0;
        r.drive   = '0;
        r.sat     = 1'b0;
      end else begin
        case (law)
          LAW_PID: begin
            err_sum = err_sum + e;
            if (err_sum > lim) err_sum = lim;
            else if (err_sum < -lim) err_sum = -lim;
            acc = scale(e, kp) + scale(e - prev_term, kd) + scale(err_sum, ki);
            clip(acc >>> FRAC_BITS, r);
            prev_term = e;
          end
          LAW_PI_ERR: begin
            acc = scale(e - prev_term, kp) + scale(e, ki);
            clip((acc >>> FRAC_BITS) + out_acc, r);
            out_acc   = $signed(r.drive);
            prev_term = e;
          end
          LAW_IP_MEAS: begin
            // proportional action on the measurement, so setpoint steps give no kick
            acc = scale(e, ki) - scale(m - prev_term, kp);
            clip((acc >>> FRAC_BITS) + out_acc, r);
            out_acc   = $signed(r.drive);
            prev_term = m;
          end
          default: begin
            acc = scale(e, kp) + scale(e - prev_term, kd);
            clip(acc >>> FRAC_BITS, r);
            prev_term = e;
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void report(string what, drive_t exp_r, logic [SIG_W-1:0] drive, logic sat);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected drive %h sat %b, got drive %h sat %b",
                 $realtime, what, exp_r.drive, exp_r.sat, drive, sat);
    endfunction

    function void check_drive(logic [SIG_W-1:0] drive, logic sat);
      drive_t exp_r;
      if (expected_q.size() == 0) begin
        exp_r.drive = 'x;
        exp_r.sat   = 1'bx;
        report("unexpected item", exp_r, drive, sat);
      end else begin
        exp_r = expected_q.pop_front();
        if (drive !== exp_r.drive || sat !== exp_r.sat) report("drive mismatch", exp_r, drive, sat);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid, s_tready;
  logic [2*SIG_W-1:0]   s_tdata;   // measurement, setpoint
  logic [0:0]           s_tuser;   // clear
  logic                 m_tvalid, m_tready;
  logic [SIG_W-1:0]     m_tdata;   // drive
  logic [0:0]           m_tuser;   // saturated

  drive_scoreboard sb;
  bit              quiet;
  bit              hold_req;
  bit              no_gaps;
  int              idle_cycles;
  logic [SIG_W-1:0] cur_meas, cur_sp;

  multi_law_pid_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    bit progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        sb.check_drive(m_tdata, m_tuser[0]);
        progress = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata[SIG_W-1:0], s_tdata[2*SIG_W-1:SIG_W], s_tuser[0]);
        progress = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        sb.set_reg(paddr[APB_AW-1:2], pwdata);
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random ready runs, a long hold-off on request
  initial begin
    bit ready_run;
    int run_left;
    run_left = 0;
    ready_run = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_run = ($urandom_range(0, 99) < 60);
          if (ready_run) run_left = $urandom_range(1, 12);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(10, 40);
          else run_left = $urandom_range(1, 3);
        end
        m_tready <= ready_run;
        run_left--;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SIG_W-1:0] rand_signal();
    logic [SIG_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = '0;
      3: v = $urandom();
      default: begin
        v = $urandom() >> $urandom_range(4, 24);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // mostly moderate gains around unity in q12.20, now and then an extreme
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(9, 28);
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom() >> $urandom_range(1, 20);
    endcase
  endfunction

  // called and left at a falling edge
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic [APB_DW-1:0] law_word, logic [GAIN_W-1:0] p,
                              logic [GAIN_W-1:0] i, logic [GAIN_W-1:0] d,
                              logic [APB_DW-1:0] lim);
    write_reg(REG_LAW, law_word);
    write_reg(REG_GAINP, p);
    write_reg(REG_GAINI, i);
    write_reg(REG_GAIND, d);
    write_reg(REG_LIMIT, lim);
  endtask

  task automatic send_sample(logic [SIG_W-1:0] meas, logic [SIG_W-1:0] sp, logic clr);
    int gap;
    gap = (quiet || no_gaps) ? 0 : rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sp, meas};
    s_tuser  <= clr;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every drive item is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_sample();
    int               r;
    logic [SIG_W-1:0] step;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      // closed-loop style: measurement creeps, setpoint steps now and then
      step = $urandom() >> $urandom_range(12, 28);
      cur_meas = $urandom_range(0, 1) ? cur_meas + step : cur_meas - step;
      if ($urandom_range(0, 9) == 0) cur_sp = rand_signal();
    end else begin
      cur_meas = rand_signal();
      cur_sp   = rand_signal();
    end
    send_sample(cur_meas, cur_sp, $urandom_range(0, 99) < 4);
  endtask

  initial begin
    int n_items;
    sb          = new();
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    no_gaps     = 1'b0;
    cur_meas    = '0;
    cur_sp      = '0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: all gains zero
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    drain();

    // positional pid, small clamp; a write to an unused index must change nothing
    write_reg(3'd7, 32'hFFFF_FFFF);
    apply_config(LAW_PID, 32'h0010_0000, 32'h0001_0000, 32'h0008_0000, 32'h0005_0000);
    send_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 32'h0002_0000, 1'b0);
    send_sample(32'h1234_5678, 32'h8765_4321, 1'b1);
    send_sample(32'h0001_0000, 32'h0000_0000, 1'b0);
    drain();

    // incremental pi with maximum gains drives the accumulator into saturation;
    // upper bits of the law word and of the limit must be ignored
    apply_config(32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();

    // proportional on measurement, previous term cleared by the last pi sample
    apply_config(LAW_IP_MEAS, 32'h0010_0000, 32'h0004_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0010_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h0001_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    drain();

    apply_config(LAW_PD, 32'h0020_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(32'h0000_1000, 32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_0000, 32'h0001_0000, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    drain();

    // zero clamp keeps the integral out entirely
    apply_config(LAW_PID, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0008_0000, 1'b0);
    send_sample(32'h0008_0000, 32'h0000_0000, 1'b0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config($urandom(), rand_gain(), rand_gain(), rand_gain(), rand_limit());
      quiet   = (ph == QUIET_PHASE);
      no_gaps = (ph == PRESSURE_PHASE);
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      n_items = $urandom_range(16, 28);
      for (int k = 0; k < n_items; k++) send_random_sample();
      no_gaps = 1'b0;
      drain();
      quiet = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
